// File: rtl/circular_double_ended_queue_top_assert.svh
// Assertion macros for the circular deque top level.
// Included by circular_double_ended_queue_top.sv; needs no other file.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Condition that must hold at every sampled edge out of reset
`define CDQ_ASSERT_ALWAYS(lbl, ck, rstn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (cond)) \
        else $error("cdq assertion failed: invariant");
// Antecedent in this cycle implies consequent in the next cycle
`define CDQ_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cdq assertion failed: next-cycle check");
`else
`define CDQ_ASSERT_ALWAYS(lbl, ck, rstn, cond)
`define CDQ_ASSERT_NEXT(lbl, ck, rstn, ante, cons)
`endif
`endif

// File: rtl/cdq_pkg.sv
// Shared types and constants for the circular deque.
// No dependencies; imported by every RTL file of the block.
package cdq_pkg;

    // Default build sizes
    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    // Fixed field widths of the beats
    localparam int CAP_W  = 5;
    localparam int VAL_W  = 32;
    localparam int OCC_W  = 5;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    // Capacity register value after reset (clamped to the built depth)
    localparam int CAP_RESET = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Sequencer states
    typedef enum logic {
        CDQ_IDLE,
        CDQ_READ
    } cdq_state_t;

    // Input beat
    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [VAL_W-1:0] push_value;
    } cdq_in_t;

    // Result beat
    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] popped_value;
        logic [OCC_W-1:0]        occupancy;
    } cdq_out_t;

endpackage

// File: rtl/cdq_slot_ram.sv
// Single-port slot memory of the circular deque, registered read data.
// Depends on cdq_pkg for default sizes.
module cdq_slot_ram #(
    parameter int DEPTH     = cdq_pkg::DEPTH_DEF,
    parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     addr,
    input  logic [WORD_BITS-1:0]         wdata,
    output logic [WORD_BITS-1:0]         rdata
);
    import cdq_pkg::*;

    logic [WORD_BITS-1:0] slot_mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    // One access per cycle: write, or read into the data register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                slot_mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= slot_mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/circular_double_ended_queue_top.sv
// Circular deque of signed words: top level with sequencer and result buffer.
// Depends on cdq_pkg, cdq_slot_ram and circular_double_ended_queue_top_assert.svh.
//
// A ring-buffer deque held in a single-port synchronous RAM of DEPTH slots.
// Each input beat pushes or pops at either end and yields exactly one result
// beat (status, popped word, occupancy after the operation). A push, or any
// operation rejected as full or empty, builds its result when accepted; a
// successful pop waits in CDQ_READ for the registered RAM read. Results leave
// through an output register backed by a one-entry skid buffer, so a new
// item is taken while an earlier result still waits. The slot RAM needs no
// clearing after reset; only written slots are ever read.
module circular_double_ended_queue_top #(
    parameter int DEPTH     = cdq_pkg::DEPTH_DEF,
    parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [cdq_pkg::CAP_W-1:0]         cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  cdq_pkg::cdq_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output cdq_pkg::cdq_out_t                 out_data
);
    import cdq_pkg::*;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CW      = IDX_W + 1;
    localparam int CAP_RST = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

    // Index stepping with wrap at the effective capacity
    function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
                                                 input logic [CW-1:0] cap);
        logic [CW-1:0] nxt;
        nxt = {1'b0, idx} + CW'(1);
        return (nxt >= cap) ? '0 : nxt[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx,
                                                   input logic [CW-1:0] cap);
        logic [CW-1:0] top;
        top = cap - CW'(1);
        return (idx == '0 || {1'b0, idx} > cap) ? top[IDX_W-1:0] : idx - IDX_W'(1);
    endfunction

    cdq_state_t state_reg, state_next;

    logic [CW-1:0]    cap_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] back_reg, back_next;

    logic                  ram_en, ram_we;
    logic [IDX_W-1:0]      ram_addr;
    logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;
    logic signed [WORD_BITS-1:0] rd_word;

    logic     in_fire;
    logic     res_load;
    cdq_out_t res;

    cdq_out_t out_data_reg, skid_data_reg;
    logic     out_valid_reg, skid_valid_reg;
    logic     out_free;

    // Capacity register, clamped to 1..DEPTH on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CW'(CAP_RST);
        end
        else if (cfg_wr_en)
        begin
            if (cfg_wr_data == '0)
            begin
                cap_reg <= CW'(1);
            end
            else if (32'(cfg_wr_data) > 32'(DEPTH))
            begin
                cap_reg <= CW'(DEPTH);
            end
            else
            begin
                cap_reg <= CW'(cfg_wr_data);
            end
        end
    end

    // Slot storage
    cdq_slot_ram #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_slot_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_word   = ram_rdata;
    assign ram_wdata = WORD_BITS'(in_data.push_value);
    assign in_fire   = in_valid && in_ready;

    // Sequencer state and deque pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CDQ_IDLE;
            count_reg <= '0;
            front_reg <= '0;
            back_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            front_reg <= front_next;
            back_reg  <= back_next;
        end
    end

    // Operation decode, pointer update, RAM access and result build
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        front_next       = front_reg;
        back_next        = back_reg;
        ram_en           = 1'b0;
        ram_we           = 1'b0;
        ram_addr         = back_reg;
        res_load         = 1'b0;
        res.status       = ST_DONE;
        res.popped_value = '0;
        res.occupancy    = OCC_W'(count_reg);
        in_ready         = (state_reg == CDQ_IDLE) && !skid_valid_reg;

        case (state_reg)
            CDQ_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_data.operation inside {OP_PUSH_BACK, OP_PUSH_FRONT})
                    begin
                        res_load = 1'b1;
                        if (count_reg >= cap_reg)
                        begin
                            res.status = ST_FULL;
                        end
                        else
                        begin
                            ram_en = 1'b1;
                            ram_we = 1'b1;
                            if (count_reg == '0)
                            begin
                                front_next = '0;
                                back_next  = '0;
                                ram_addr   = '0;
                            end
                            else if (in_data.operation == OP_PUSH_BACK)
                            begin
                                back_next = step_up(back_reg, cap_reg);
                                ram_addr  = back_next;
                            end
                            else
                            begin
                                front_next = step_down(front_reg, cap_reg);
                                ram_addr   = front_next;
                            end
                            count_next    = count_reg + CW'(1);
                            res.occupancy = OCC_W'(count_next);
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_load   = 1'b1;
                            res.status = ST_EMPTY;
                        end
                        else
                        begin
                            // Read the slot now, deliver it next cycle
                            ram_en = 1'b1;
                            if (in_data.operation == OP_POP_BACK)
                            begin
                                ram_addr  = back_reg;
                                back_next = step_down(back_reg, cap_reg);
                            end
                            else
                            begin
                                ram_addr   = front_reg;
                                front_next = step_up(front_reg, cap_reg);
                            end
                            count_next = count_reg - CW'(1);
                            if (count_next == '0)
                            begin
                                front_next = '0;
                                back_next  = '0;
                            end
                            state_next = CDQ_READ;
                        end
                    end
                end
            end
            CDQ_READ:
            begin
                res_load         = 1'b1;
                res.popped_value = VAL_W'(rd_word);
                state_next       = CDQ_IDLE;
            end
            default:
            begin
                state_next = CDQ_IDLE;
            end
        endcase
    end

    // Output register with one-entry skid buffer
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= res_load;
            end
            else
            begin
                out_valid_reg <= res_load;
            end
        end
        else if (res_load)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                if (res_load)
                begin
                    skid_data_reg <= res;
                end
            end
            else if (res_load)
            begin
                out_data_reg <= res;
            end
        end
        else if (res_load)
        begin
            skid_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
`include "circular_double_ended_queue_top_assert.svh"

    `CDQ_ASSERT_ALWAYS(a_skid_behind_out, clk, rst_n, !skid_valid_reg || out_valid_reg)
    `CDQ_ASSERT_ALWAYS(a_empty_at_origin, clk, rst_n,
        count_reg != '0 || (front_reg == '0 && back_reg == '0))
    `CDQ_ASSERT_NEXT(a_read_delivers, clk, rst_n, state_reg == CDQ_READ,
        state_reg == CDQ_IDLE && out_valid_reg)
    `CDQ_ASSERT_NEXT(a_push_counts, clk, rst_n, ram_en && ram_we,
        count_reg == $past(count_reg) + CW'(1))

endmodule

// File: sim/circular_double_ended_queue_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for circular_double_ended_queue_top: random and directed deque traffic.
// Depends on cdq_pkg and the RTL of the deque; a tracking class predicts every result beat.

module circular_double_ended_queue_top_tb;

    import cdq_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_OFF_LEN = 300;
    localparam int PHASE_ITEMS  = 238;
    localparam int PHASES       = 8;

    // Deque tracker: mirrors ring state, holds the results still due
    class deque_tracker;
        logic signed [VAL_W-1:0] slot_word [DEPTH_DEF];
        int unsigned             head_slot;
        int unsigned             tail_slot;
        int unsigned             held;
        logic [CAP_W-1:0]        cap_raw;
        cdq_out_t                results_due [$];
        int unsigned             mismatches;
        int unsigned             beats_checked;
        int unsigned             full_refusals;
        int unsigned             empty_refusals;

        function new();
            foreach (slot_word[i]) slot_word[i] = '0;
            head_slot      = 0;
            tail_slot      = 0;
            held           = 0;
            cap_raw        = CAP_W'(CAP_RESET);
            mismatches     = 0;
            beats_checked  = 0;
            full_refusals  = 0;
            empty_refusals = 0;
        endfunction

        // Written value clamped into 1..DEPTH
        function int unsigned usable_slots();
            if (cap_raw == 0)
                return 1;
            if (cap_raw > DEPTH_DEF)
                return DEPTH_DEF;
            return int'(cap_raw);
        endfunction

        function int unsigned slot_after(int unsigned idx, int unsigned lim);
            return (idx + 1 >= lim) ? 0 : idx + 1;
        endfunction

        // Index may sit above a shrunk capacity; it then lands on the top slot
        function int unsigned slot_before(int unsigned idx, int unsigned lim);
            if (idx == 0 || idx > lim)
                return lim - 1;
            return idx - 1;
        endfunction

        // Apply one accepted operation and queue the result it must give
        function void note_item(cdq_in_t beat);
            cdq_out_t    res;
            int unsigned lim;
            lim              = usable_slots();
            res.status       = ST_DONE;
            res.popped_value = '0;
            if (beat.operation == OP_PUSH_BACK || beat.operation == OP_PUSH_FRONT)
            begin
                if (held >= lim)
                begin
                    res.status = ST_FULL;
                    full_refusals++;
                end
                else
                begin
                    if (held == 0)
                    begin
                        head_slot = 0;
                        tail_slot = 0;
                    end
                    else if (beat.operation == OP_PUSH_BACK)
                        tail_slot = slot_after(tail_slot, lim);
                    else
                        head_slot = slot_before(head_slot, lim);
                    if (beat.operation == OP_PUSH_BACK)
                        slot_word[tail_slot % DEPTH_DEF] = beat.push_value;
                    else
                        slot_word[head_slot % DEPTH_DEF] = beat.push_value;
                    held++;
                end
            end
            else
            begin
                if (held == 0)
                begin
                    res.status = ST_EMPTY;
                    empty_refusals++;
                end
                else
                begin
                    if (beat.operation == OP_POP_BACK)
                    begin
                        res.popped_value = slot_word[tail_slot % DEPTH_DEF];
                        tail_slot        = slot_before(tail_slot, lim);
                    end
                    else
                    begin
                        res.popped_value = slot_word[head_slot % DEPTH_DEF];
                        head_slot        = slot_after(head_slot, lim);
                    end
                    held--;
                    // last item gone: both ends back to slot 0
                    if (held == 0)
                    begin
                        head_slot = 0;
                        tail_slot = 0;
                    end
                end
            end
            res.occupancy = OCC_W'(held);
            results_due.push_back(res);
        endfunction

        task report_mismatch(input string msg);
            if (mismatches < 40)
                $display("[%0t] MISMATCH on result %0d: %s", $time, beats_checked, msg);
            mismatches++;
        endtask

        // Compare a result beat with the oldest one due
        task check_result(input cdq_out_t got);
            cdq_out_t want;
            if (results_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat status=%0d value=%0d occ=%0d",
                                          got.status, got.popped_value, got.occupancy));
                return;
            end
            want = results_due.pop_front();
            beats_checked++;
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.popped_value !== want.popped_value)
                report_mismatch($sformatf("popped_value %0d, want %0d",
                                          got.popped_value, want.popped_value));
            if (got.occupancy !== want.occupancy)
                report_mismatch($sformatf("occupancy %0d, want %0d",
                                          got.occupancy, want.occupancy));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_ready;
    cdq_in_t          in_data;
    logic             out_valid;
    logic             out_ready = 1'b0;
    cdq_out_t         out_data;

    deque_tracker board = new();

    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_stall_pct = 0;
    logic        hold_off_req  = 1'b0;
    logic        hold_off_ack  = 1'b0;
    int unsigned hold_off_left = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned items_taken   = 0;
    int unsigned cap_writes    = 0;

    logic [CAP_W-1:0] cap_plan [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd2, 5'd9};
    int unsigned      send_pct_plan [4] = '{0, 54, 0, 30};
    int unsigned      recv_pct_plan [4] = '{0, 0, 54, 30};

    circular_double_ended_queue_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_off_req != hold_off_ack)
        begin
            hold_off_ack  <= hold_off_req;
            hold_off_left <= HOLD_OFF_LEN;
            out_ready     <= 1'b0;
        end
        else if (hold_off_left != 0)
        begin
            hold_off_left <= hold_off_left - 1;
            out_ready     <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Beat monitor: results checked before the new item is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(out_data);
            if (in_valid && in_ready)
            begin
                board.note_item(in_data);
                items_taken++;
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[%0t] watchdog: no beat for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic cdq_in_t make_item(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] word);
        cdq_in_t beat;
        beat.operation  = op;
        beat.push_value = word;
        return beat;
    endfunction

    // Random operation; push_bias is the push share in percent
    function automatic cdq_in_t random_item(int unsigned push_bias);
        logic signed [VAL_W-1:0] word;
        logic                    push;
        logic                    at_back;
        case ($urandom_range(7))
            0:       word = 32'sh7FFF_FFFF;
            1:       word = 32'sh8000_0000;
            2:       word = '0;
            3:       word = '1;
            default: word = $urandom;
        endcase
        push    = ($urandom_range(99) < push_bias);
        at_back = 1'($urandom_range(1));
        if (push)
            return make_item(at_back ? OP_PUSH_BACK : OP_PUSH_FRONT, word);
        return make_item(at_back ? OP_POP_BACK : OP_POP_FRONT, word);
    endfunction

    // Offer one beat after a random gap and hold it until taken
    task automatic send_item(input cdq_in_t beat);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!in_ready);
    endtask

    // Capacity write once every result is out and the block has settled
    task automatic write_capacity(input logic [CAP_W-1:0] raw);
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= raw;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        board.cap_raw = raw;
        cap_writes++;
    endtask

    initial
    begin
        int unsigned push_bias;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pops, front wrap from slot 0, last item leaving
        // at a nonzero slot, then a fill that writes every slot, then full
        send_item(make_item(OP_POP_BACK, 32'sd0));
        send_item(make_item(OP_POP_FRONT, 32'sd0));
        send_item(make_item(OP_PUSH_BACK, 32'sh7FFF_FFFF));
        send_item(make_item(OP_PUSH_FRONT, 32'sh8000_0000));
        send_item(make_item(OP_POP_BACK, 32'sd0));
        send_item(make_item(OP_POP_FRONT, 32'sd0));
        for (int i = 0; i < 16; i++)
        begin
            case (i % 4)
                0: send_item(make_item(OP_PUSH_BACK, 32'sh7FFF_FFFF - i));
                1: send_item(make_item(OP_PUSH_FRONT, 32'sh8000_0000 + i));
                2: send_item(make_item(OP_PUSH_BACK, -i));
                default: send_item(make_item(OP_PUSH_FRONT, 32'sh5A5A_A5A5 ^ i));
            endcase
        end
        send_item(make_item(OP_PUSH_BACK, 32'sd1));
        send_item(make_item(OP_PUSH_FRONT, -32'sd1));

        // Random phases: capacity and idle mode change between them
        for (int p = 0; p < PHASES; p++)
        begin
            sender_idle_pct    = send_pct_plan[p % 4];
            receiver_stall_pct = recv_pct_plan[p % 4];
            write_capacity(cap_plan[p]);
            if (p == 0)
            begin
                // long receiver hold-off with the sender still sending
                hold_off_req <= ~hold_off_req;
                for (int i = 0; i < 40; i++)
                    send_item(random_item(50));
            end
            push_bias = 50;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 16 == 0)
                    case ($urandom_range(2))
                        0:       push_bias = 80;
                        1:       push_bias = 20;
                        default: push_bias = 50;
                    endcase
                send_item(random_item(push_bias));
            end
        end

        // Drain and let any stray beat show up
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.results_due.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("Run covered %0d operations and %0d checked results over %0d capacity writes",
                 items_taken, board.beats_checked, cap_writes);
        $display("Refused pushes (full): %0d, refused pops (empty): %0d, mismatches: %0d",
                 board.full_refusals, board.empty_refusals, board.mismatches);
        if (board.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
